// ===== rtl/core/dcc_pkg.sv =====
// dcc_pkg: shared types, sizes and codes of the dag cycle checker
// used by dcc_ctrl, dcc_datapath, dag_cycle_checker and dcc_checker
// no dependencies
package dcc_pkg;

	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 256;
	localparam int ID_W      = 6;
	localparam int NODE_AW   = $clog2(MAX_NODES);
	localparam int NCW       = $clog2(MAX_NODES + 1);
	localparam int EDGE_AW   = $clog2(MAX_EDGES);
	localparam int ECW       = $clog2(MAX_EDGES + 1);
	localparam int DEG_W     = $clog2(MAX_EDGES + 1);
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 7;
	localparam int KIND_W    = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD_NODE = 2'd0,
		KIND_ADD_EDGE = 2'd1,
		KIND_VALIDATE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_MISS_SRC = 3'd1,
		ST_MISS_TGT = 3'd2,
		ST_NO_START = 3'd3,
		ST_CYCLE    = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef struct packed {
		logic    node_add;
		logic    edge_add;
		logic    deg_inc;
		logic    start;
		logic    scan_rd;
		logic    e_inc;
		logic    init_rd;
		logic    init_wr;
		logic    i_inc;
		logic    q_rd;
		logic    pop_take;
		logic    work_rd;
		logic    work_upd;
		logic    res_load;
		logic    res_count;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic overflow;
		logic nodes_zero;
		logic edge_full;
		logic out_busy;
		logic e_end;
		logic src_present;
		logic tgt_present;
		logic src_is_cur;
		logic i_last;
		logic tail_zero_next;
		logic q_empty;
		logic done_ne;
	} sts_t;

endpackage

// ===== rtl/core/dcc_ctrl.sv =====
// dcc_ctrl: sequencer for node/edge loads and the validate walk
// depends on dcc_pkg; drives dcc_datapath through cmd_t, reads sts_t
module dcc_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [dcc_pkg::KIND_W-1:0] in_kind,
	output logic                     in_ready,
	input  dcc_pkg::sts_t            sts,
	output dcc_pkg::cmd_t            cmd
);

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_INC      = 11'b000_0000_0010,
		S_SCAN_RD  = 11'b000_0000_0100,
		S_SCAN_CHK = 11'b000_0000_1000,
		S_INIT_RD  = 11'b000_0001_0000,
		S_INIT_WR  = 11'b000_0010_0000,
		S_POP      = 11'b000_0100_0000,
		S_POP_WAIT = 11'b000_1000_0000,
		S_EDGE_RD  = 11'b001_0000_0000,
		S_EDGE_CHK = 11'b010_0000_0000,
		S_WORK_UPD = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE) &&
		!((in_kind == dcc_pkg::KIND_VALIDATE) && sts.out_busy);
	assign accept = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.res_status = dcc_pkg::ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_kind)
						dcc_pkg::KIND_ADD_NODE: cmd.node_add = 1'b1;
						dcc_pkg::KIND_ADD_EDGE: begin
							cmd.edge_add = 1'b1;
							if (!sts.edge_full) state_d = S_INC;
						end
						dcc_pkg::KIND_VALIDATE: begin
							if (sts.overflow) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = dcc_pkg::ST_OVERFLOW;
							end else if (sts.nodes_zero) begin
								cmd.res_load   = 1'b1;
								cmd.res_status = dcc_pkg::ST_OK;
							end else begin
								cmd.start = 1'b1;
								state_d   = S_SCAN_RD;
							end
						end
						default: ;
					endcase
				end
			end
			S_INC: begin
				cmd.deg_inc = 1'b1;
				state_d     = S_IDLE;
			end
			S_SCAN_RD: begin
				if (sts.e_end) begin
					state_d = S_INIT_RD;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				priority if (!sts.src_present) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = dcc_pkg::ST_MISS_SRC;
					state_d        = S_IDLE;
				end else if (!sts.tgt_present) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = dcc_pkg::ST_MISS_TGT;
					state_d        = S_IDLE;
				end else begin
					cmd.e_inc = 1'b1;
					state_d   = S_SCAN_RD;
				end
			end
			S_INIT_RD: begin
				cmd.init_rd = 1'b1;
				state_d     = S_INIT_WR;
			end
			S_INIT_WR: begin
				cmd.init_wr = 1'b1;
				if (sts.i_last) begin
					if (sts.tail_zero_next) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = dcc_pkg::ST_NO_START;
						state_d        = S_IDLE;
					end else begin
						state_d = S_POP;
					end
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_INIT_RD;
				end
			end
			S_POP: begin
				if (sts.q_empty) begin
					cmd.res_load   = 1'b1;
					cmd.res_count  = 1'b1;
					cmd.res_status = sts.done_ne ? dcc_pkg::ST_CYCLE : dcc_pkg::ST_OK;
					state_d        = S_IDLE;
				end else begin
					cmd.q_rd = 1'b1;
					state_d  = S_POP_WAIT;
				end
			end
			S_POP_WAIT: begin
				cmd.pop_take = 1'b1;
				state_d      = S_EDGE_RD;
			end
			S_EDGE_RD: begin
				if (sts.e_end) begin
					state_d = S_POP;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_EDGE_CHK;
				end
			end
			S_EDGE_CHK: begin
				if (sts.src_is_cur) begin
					cmd.work_rd = 1'b1;
					state_d     = S_WORK_UPD;
				end else begin
					cmd.e_inc = 1'b1;
					state_d   = S_EDGE_RD;
				end
			end
			S_WORK_UPD: begin
				cmd.work_upd = 1'b1;
				cmd.e_inc    = 1'b1;
				state_d      = S_EDGE_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/dcc_datapath.sv =====
// dcc_datapath: graph storage, walk counters, ready queue and result register
// depends on dcc_pkg; commanded by dcc_ctrl
module dcc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dcc_pkg::ID_W-1:0]    in_node_id,
	input  logic [dcc_pkg::ID_W-1:0]    in_target_id,
	input  dcc_pkg::cmd_t               cmd,
	output dcc_pkg::sts_t               sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dcc_pkg::STATUS_W-1:0] out_status,
	output logic [dcc_pkg::ID_W-1:0]    out_bad_node,
	output logic [dcc_pkg::COUNT_W-1:0] out_count
);

	logic [dcc_pkg::MAX_NODES-1:0] present_q;
	logic [dcc_pkg::NCW-1:0]       node_cnt_q;
	logic [dcc_pkg::ECW-1:0]       edge_cnt_q;
	logic                          ovf_q;
	logic [dcc_pkg::NODE_AW-1:0]   dst_q;

	logic [2*dcc_pkg::ID_W-1:0]    edge_mem [dcc_pkg::MAX_EDGES];
	logic [2*dcc_pkg::ID_W-1:0]    edge_rd_q;
	logic [dcc_pkg::DEG_W-1:0]     deg_mem [dcc_pkg::MAX_NODES];
	logic [dcc_pkg::MAX_NODES-1:0] deg_vld_q;
	logic [dcc_pkg::DEG_W-1:0]     deg_rd_q;
	logic                          deg_rd_vld_q;
	logic [dcc_pkg::DEG_W-1:0]     work_mem [dcc_pkg::MAX_NODES];
	logic [dcc_pkg::DEG_W-1:0]     work_rd_q;
	logic [dcc_pkg::NODE_AW-1:0]   que_mem [dcc_pkg::MAX_NODES];
	logic [dcc_pkg::NODE_AW-1:0]   que_rd_q;

	logic [dcc_pkg::ECW-1:0]       e_q;
	logic [dcc_pkg::NODE_AW-1:0]   i_q;
	logic [dcc_pkg::NCW-1:0]       head_q, tail_q, done_q;
	logic [dcc_pkg::NODE_AW-1:0]   cur_q, tgt_q;

	logic                          m_valid_q;
	logic [dcc_pkg::STATUS_W-1:0]  status_q;
	logic [dcc_pkg::ID_W-1:0]      bad_q;
	logic [dcc_pkg::COUNT_W-1:0]   count_q;

	logic [dcc_pkg::ID_W-1:0]      e_src, e_tgt;
	logic [dcc_pkg::DEG_W-1:0]     deg_val;
	logic                          edge_full, init_push, work_push, work_nz;
	logic [dcc_pkg::NODE_AW-1:0]   deg_raddr;

	assign e_src     = edge_rd_q[dcc_pkg::ID_W-1:0];
	assign e_tgt     = edge_rd_q[2*dcc_pkg::ID_W-1:dcc_pkg::ID_W];
	assign deg_val   = deg_rd_vld_q ? deg_rd_q : '0;
	assign edge_full = (edge_cnt_q == dcc_pkg::ECW'(dcc_pkg::MAX_EDGES));
	assign init_push = cmd.init_wr && present_q[i_q] && (deg_val == '0);
	assign work_nz   = (work_rd_q != '0);
	// push when this edge brings the target down to zero and the queue has room
	assign work_push = cmd.work_upd && (work_rd_q == dcc_pkg::DEG_W'(1)) &&
		(tail_q != dcc_pkg::NCW'(dcc_pkg::MAX_NODES));
	assign deg_raddr = cmd.init_rd ? i_q : in_target_id;

	assign sts.overflow       = ovf_q;
	assign sts.nodes_zero     = (node_cnt_q == '0);
	assign sts.edge_full      = edge_full;
	assign sts.out_busy       = m_valid_q;
	assign sts.e_end          = (e_q == edge_cnt_q);
	assign sts.src_present    = present_q[e_src];
	assign sts.tgt_present    = present_q[e_tgt];
	assign sts.src_is_cur     = (e_src == cur_q);
	assign sts.i_last         = (i_q == dcc_pkg::NODE_AW'(dcc_pkg::MAX_NODES - 1));
	assign sts.tail_zero_next = (tail_q == '0) && !init_push;
	assign sts.q_empty        = (head_q == tail_q);
	assign sts.done_ne        = (done_q != node_cnt_q);

	// memories
	always_ff @(posedge clk) begin
		if (cmd.edge_add && !edge_full)
			edge_mem[edge_cnt_q[dcc_pkg::EDGE_AW-1:0]] <= {in_target_id, in_node_id};
		if (cmd.scan_rd)
			edge_rd_q <= edge_mem[e_q[dcc_pkg::EDGE_AW-1:0]];
		if (cmd.deg_inc)
			deg_mem[dst_q] <= deg_val + dcc_pkg::DEG_W'(1);
		if (cmd.edge_add || cmd.init_rd)
			deg_rd_q <= deg_mem[deg_raddr];
		if (cmd.init_wr)
			work_mem[i_q] <= deg_val;
		else if (cmd.work_upd && work_nz)
			work_mem[tgt_q] <= work_rd_q - dcc_pkg::DEG_W'(1);
		if (cmd.work_rd)
			work_rd_q <= work_mem[e_tgt];
		if (init_push)
			que_mem[tail_q[dcc_pkg::NODE_AW-1:0]] <= i_q;
		else if (work_push)
			que_mem[tail_q[dcc_pkg::NODE_AW-1:0]] <= tgt_q;
		if (cmd.q_rd)
			que_rd_q <= que_mem[head_q[dcc_pkg::NODE_AW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.edge_add)
			dst_q <= in_target_id;
		if (cmd.pop_take)
			cur_q <= que_rd_q;
		if (cmd.work_rd)
			tgt_q <= e_tgt;
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			priority case (cmd.res_status)
				dcc_pkg::ST_MISS_SRC: bad_q <= e_src;
				dcc_pkg::ST_MISS_TGT: bad_q <= e_tgt;
				default:              bad_q <= '0;
			endcase
			count_q <= cmd.res_count ? dcc_pkg::COUNT_W'(done_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			node_cnt_q   <= '0;
			edge_cnt_q   <= '0;
			ovf_q        <= 1'b0;
			deg_vld_q    <= '0;
			deg_rd_vld_q <= 1'b0;
			e_q          <= '0;
			i_q          <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			done_q       <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cmd.node_add && !present_q[in_node_id]) begin
				present_q[in_node_id] <= 1'b1;
				node_cnt_q            <= node_cnt_q + dcc_pkg::NCW'(1);
			end
			if (cmd.edge_add) begin
				if (edge_full) ovf_q <= 1'b1;
				else edge_cnt_q <= edge_cnt_q + dcc_pkg::ECW'(1);
			end
			if (cmd.edge_add || cmd.init_rd)
				deg_rd_vld_q <= deg_vld_q[deg_raddr];
			if (cmd.deg_inc)
				deg_vld_q[dst_q] <= 1'b1;
			if (cmd.start) begin
				e_q    <= '0;
				i_q    <= '0;
				head_q <= '0;
				tail_q <= '0;
				done_q <= '0;
			end else begin
				if (cmd.pop_take) begin
					e_q    <= '0;
					head_q <= head_q + dcc_pkg::NCW'(1);
					done_q <= done_q + dcc_pkg::NCW'(1);
				end else if (cmd.e_inc) begin
					e_q <= e_q + dcc_pkg::ECW'(1);
				end
				if (cmd.i_inc)
					i_q <= i_q + dcc_pkg::NODE_AW'(1);
				if (init_push || work_push)
					tail_q <= tail_q + dcc_pkg::NCW'(1);
			end
			if (cmd.res_load)
				m_valid_q <= 1'b1;
			else if (out_ready)
				m_valid_q <= 1'b0;
		end
	end

	assign out_valid    = m_valid_q;
	assign out_status   = status_q;
	assign out_bad_node = bad_q;
	assign out_count    = count_q;

endmodule

// ===== rtl/core/dag_cycle_checker.sv =====
// dag_cycle_checker: dependency graph builder with kahn topological check
// depends on dcc_pkg, dcc_ctrl, dcc_datapath
//
// channel  dir  signals                      beat content
// s_*      in   tvalid tready tdata tuser    one node, edge or validate request
// m_*      out  tvalid tready tdata          one validate status
//
// add node is done at its accept, add edge reads then writes the in-degree
// validate: an accept, then the endpoint scan over the stored edges, the in-degree
//   pass over every node slot, per peeled node a pass over the stored edges
//   with an update per edge leaving it, and a closing step to end the walk
// overflow or empty graph: the status is out the cycle after the accepting edge
// a validate beat waits while an earlier status is still untaken; others do not
// reset clears node flags, in-degree valid bits, counts and the overflow flag
module dag_cycle_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // node_id[5:0], target_id[11:6], zero fill
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[2:0], bad_node[8:3], nodes_done[15:9]
);

	dcc_pkg::cmd_t cmd;
	dcc_pkg::sts_t sts;
	logic [dcc_pkg::STATUS_W-1:0] status;
	logic [dcc_pkg::ID_W-1:0]     bad_node;
	logic [dcc_pkg::COUNT_W-1:0]  walk_count;

	dcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dcc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_node_id   (s_tdata[5:0]),
		.in_target_id (s_tdata[11:6]),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_status   (status),
		.out_bad_node (bad_node),
		.out_count    (walk_count)
	);

	assign m_tdata = {walk_count, bad_node, status};

endmodule

// ===== rtl/core/dcc_checker.sv =====
// dcc_checker: port-level assertions for dag_cycle_checker
// depends on dcc_pkg; bound to the top level below
module dcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("status beat changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= dcc_pkg::ST_OVERFLOW)
		else $error("status code out of range");

	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != dcc_pkg::ST_MISS_SRC &&
		m_tdata[2:0] != dcc_pkg::ST_MISS_TGT |-> m_tdata[8:3] == 6'd0)
		else $error("bad_node set without missing endpoint");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != dcc_pkg::ST_OK &&
		m_tdata[2:0] != dcc_pkg::ST_CYCLE |-> m_tdata[15:9] == 7'd0)
		else $error("count set on an early-exit status");

	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] <= 7'(dcc_pkg::MAX_NODES))
		else $error("count above node capacity");

endmodule

bind dag_cycle_checker dcc_checker u_dcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== sim/dag_cycle_checker_tb.sv =====
// dag_cycle_checker_tb: self-checking bench for the dag cycle checker
// drives node, edge and validate beats, predicts each status in place
// depends on dcc_pkg and the dag_cycle_checker rtl
`timescale 1ns / 1ps

module dag_cycle_checker_tb;
	import dcc_pkg::*;

	localparam logic [KIND_W-1:0] KIND_RSVD = 2'd3;
	localparam int HALF_PERIOD = 6;
	localparam int RAND_ITEMS  = 300;
	// rough count of all beats sent, used to split the idling phases
	localparam int ALL_ITEMS   = 540;

	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   bad_node;
		logic [COUNT_W-1:0] processed;
	} graph_status_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   node_id;
		logic [ID_W-1:0]   target_id;
		bit                typed;
		graph_status_t     want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	// shadow copy of the graph
	bit              node_reg [MAX_NODES];
	int              indeg [MAX_NODES];
	logic [ID_W-1:0] edge_src [MAX_EDGES];
	logic [ID_W-1:0] edge_tgt [MAX_EDGES];
	int              n_edges;
	bit              edge_ovf;

	graph_status_t status_q[$];
	int            n_errors;
	int            n_sent;
	int            idle_send;
	int            idle_recv;
	bit            hold_done;
	int            hold_left;

	dag_cycle_checker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic graph_status_t kahn_status();
		graph_status_t r;
		int nodes, head, tail, done, cur;
		int work [MAX_NODES];
		int ready [MAX_NODES];
		r = '{ST_OK, '0, '0};
		nodes = 0; head = 0; tail = 0; done = 0;
		if (edge_ovf) begin
			r.status = ST_OVERFLOW;
			return r;
		end
		foreach (node_reg[i]) if (node_reg[i]) nodes++;
		if (nodes == 0) return r;
		for (int e = 0; e < n_edges; e++) begin
			if (!node_reg[edge_src[e]]) begin
				r.status = ST_MISS_SRC; r.bad_node = edge_src[e];
				return r;
			end
			if (!node_reg[edge_tgt[e]]) begin
				r.status = ST_MISS_TGT; r.bad_node = edge_tgt[e];
				return r;
			end
		end
		for (int i = 0; i < MAX_NODES; i++) begin
			work[i] = indeg[i];
			if (node_reg[i] && indeg[i] == 0) ready[tail++] = i;
		end
		if (tail == 0) begin
			r.status = ST_NO_START;
			return r;
		end
		while (head < tail) begin
			cur = ready[head++];
			done++;
			for (int e = 0; e < n_edges; e++) begin
				if (edge_src[e] != cur || work[edge_tgt[e]] == 0) continue;
				work[edge_tgt[e]]--;
				if (work[edge_tgt[e]] == 0 && tail < MAX_NODES) ready[tail++] = edge_tgt[e];
			end
		end
		r.status = (done != nodes) ? ST_CYCLE : ST_OK;
		r.processed = done[COUNT_W-1:0];
		return r;
	endfunction

	// updates the shadow graph and returns 1 when a status is due
	function automatic bit apply_beat(logic [KIND_W-1:0] k, logic [ID_W-1:0] n,
			logic [ID_W-1:0] t);
		case (k)
			KIND_ADD_NODE: node_reg[n] = 1'b1;
			KIND_ADD_EDGE: begin
				if (n_edges >= MAX_EDGES) begin
					edge_ovf = 1'b1;
				end else begin
					edge_src[n_edges] = n;
					edge_tgt[n_edges] = t;
					n_edges++;
					indeg[t]++;
				end
			end
			KIND_VALIDATE: return 1'b1;
			default: ;
		endcase
		return 1'b0;
	endfunction

	task automatic send_beat(logic [KIND_W-1:0] k, logic [ID_W-1:0] n,
			logic [ID_W-1:0] t, bit typed, graph_status_t want);
		@(negedge clk);
		if ($urandom_range(99) < idle_send) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_send);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {4'b0, t, n};
		do @(posedge clk); while (!s_tready);
		if (apply_beat(k, n, t))
			status_q.insert(status_q.size(), typed ? want : kahn_status());
		n_sent++;
		if (n_sent == ALL_ITEMS / 3) begin
			idle_send = 66; idle_recv = 34;
		end else if (n_sent == 2 * ALL_ITEMS / 3) begin
			idle_send = 0; idle_recv = 0;
		end
	endtask

	task automatic send_plain(logic [KIND_W-1:0] k, logic [ID_W-1:0] n,
			logic [ID_W-1:0] t);
		send_beat(k, n, t, 1'b0, '{ST_OK, '0, '0});
	endtask

	// receiver: random stalls plus one long hold-off early on
	always @(negedge clk) begin
		if (!hold_done && n_sent >= 40) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= idle_recv);
		end
	end

	always @(posedge clk) begin
		graph_status_t got, exp_st;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[2:0], m_tdata[8:3], m_tdata[15:9]};
			if (status_q.size() == 0) begin
				$error("status beat with none expected: %h", m_tdata);
				n_errors++;
			end else begin
				exp_st = status_q.pop_front();
				if (got.status !== exp_st.status) begin
					$error("status: expected %0d, actual %0d", exp_st.status, got.status);
					n_errors++;
				end
				if (got.bad_node !== exp_st.bad_node) begin
					$error("bad_node: expected %0d, actual %0d", exp_st.bad_node,
						got.bad_node);
					n_errors++;
				end
				if (got.processed !== exp_st.processed) begin
					$error("nodes_processed: expected %0d, actual %0d", exp_st.processed,
						got.processed);
					n_errors++;
				end
			end
		end
	end

	initial begin
		#(2 * HALF_PERIOD * 20_000_000);
		$display("FAIL");
		$finish;
	end

	initial begin
		stim_row_t rows [$];
		int r;
		logic [ID_W-1:0] a, b, la, lb;
		clk = 1'b0; arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
		n_errors = 0; n_sent = 0; hold_done = 1'b0; hold_left = 0;
		idle_send = 34; idle_recv = 66;
		n_edges = 0; edge_ovf = 1'b0; la = '0; lb = ID_W'(1);
		foreach (node_reg[i]) begin
			node_reg[i] = 1'b0; indeg[i] = 0;
		end

		rows = '{
			'{KIND_VALIDATE, 6'd0,  6'd0,  1, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_ADD_NODE, 6'd10, 6'd0,  0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_VALIDATE, 6'd0,  6'd0,  1, '{ST_OK, 6'd0, 7'd1}},
			'{KIND_ADD_EDGE, 6'd3,  6'd10, 0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_VALIDATE, 6'd0,  6'd0,  1, '{ST_MISS_SRC, 6'd3, 7'd0}},
			'{KIND_ADD_NODE, 6'd3,  6'd63, 0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_VALIDATE, 6'd63, 6'd63, 0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_ADD_EDGE, 6'd0,  6'd63, 0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_VALIDATE, 6'd0,  6'd0,  1, '{ST_MISS_SRC, 6'd0, 7'd0}},
			'{KIND_ADD_NODE, 6'd0,  6'd0,  0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_VALIDATE, 6'd0,  6'd0,  1, '{ST_MISS_TGT, 6'd63, 7'd0}},
			'{KIND_ADD_NODE, 6'd63, 6'd0,  0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_ADD_NODE, 6'd63, 6'd63, 0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_RSVD,     6'd63, 6'd63, 0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_VALIDATE, 6'd0,  6'd0,  0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_ADD_EDGE, 6'd3,  6'd10, 0, '{ST_OK, 6'd0, 7'd0}},
			'{KIND_VALIDATE, 6'd0,  6'd0,  0, '{ST_OK, 6'd0, 7'd0}}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			send_beat(rows[i].kind, rows[i].node_id, rows[i].target_id, rows[i].typed,
				rows[i].want);

		// forward edges only, so the graph stays acyclic until the closing part
		for (int i = 0; i < RAND_ITEMS; i++) begin
			r = $urandom_range(99);
			a = ID_W'($urandom_range(62));
			b = ID_W'($urandom_range(63, a + 1));
			if (r < 34) begin
				if ($urandom_range(9) == 0) begin
					a = la; b = lb;
				end
				la = a; lb = b;
				send_plain(KIND_ADD_EDGE, a, b);
			end else if (r < 41) begin
				send_plain(KIND_VALIDATE, ID_W'($urandom), ID_W'($urandom));
			end else if (r < 46) begin
				send_plain(KIND_RSVD, ID_W'($urandom), ID_W'($urandom));
			end else begin
				send_plain(KIND_ADD_NODE, ID_W'($urandom), ID_W'($urandom));
			end
		end

		// every node present, then a back edge makes a cycle
		for (int i = 0; i < MAX_NODES; i++) send_plain(KIND_ADD_NODE, ID_W'(i), '0);
		send_plain(KIND_VALIDATE, '0, '0);
		send_plain(KIND_ADD_EDGE, 6'd63, 6'd0);
		send_plain(KIND_VALIDATE, '0, '0);
		// a ring through every node leaves no start node
		for (int i = 0; i < MAX_NODES; i++)
			send_plain(KIND_ADD_EDGE, ID_W'(i), ID_W'((i + 1) % MAX_NODES));
		send_plain(KIND_VALIDATE, '0, '0);
		// fill the edge store to capacity, then past it
		while (n_edges < MAX_EDGES)
			send_plain(KIND_ADD_EDGE, ID_W'($urandom), ID_W'($urandom));
		send_plain(KIND_VALIDATE, '0, '0);
		send_plain(KIND_ADD_EDGE, ID_W'($urandom), ID_W'($urandom));
		send_plain(KIND_ADD_EDGE, ID_W'($urandom), ID_W'($urandom));
		send_plain(KIND_VALIDATE, '0, '0);
		send_plain(KIND_ADD_NODE, 6'd5, '0);
		send_plain(KIND_VALIDATE, '0, '0);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
